@@ hw/rtl/kic_pkg.sv @@
// kic_pkg: types, codes and sizes for the keypad ID enroll and check block.
// Holds the key map table and the word structs for both directions.
// No dependencies.
`default_nettype none
package kic_pkg;

	localparam int MaxEntries = 32;
	localparam int IdDigits   = 4;
	localparam int IdW        = 4 * IdDigits;
	localparam int CntW       = $clog2(MaxEntries + 1);
	localparam int AddrW      = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
	localparam int EcntW      = $clog2(IdDigits + 1);
	localparam int NibW       = (IdDigits > 1) ? $clog2(IdDigits) : 1;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_MODE = 1'b1;

	localparam logic [3:0] POS_ACCEPT = 4'd0;
	localparam logic [3:0] POS_CANCEL = 4'd15;

	localparam logic [2:0] EV_ECHO         = 3'd0;
	localparam logic [2:0] EV_MATCHED      = 3'd1;
	localparam logic [2:0] EV_NOT_ENROLLED = 3'd2;
	localparam logic [2:0] EV_EXISTS       = 3'd3;
	localparam logic [2:0] EV_REGISTERED   = 3'd4;
	localparam logic [2:0] EV_FULL         = 3'd5;
	localparam logic [2:0] EV_MODE         = 3'd6;
	localparam logic [2:0] EV_CANCEL       = 3'd7;

	localparam logic [1:0] BEEP_NONE  = 2'd0;
	localparam logic [1:0] BEEP_SHORT = 2'd1;
	localparam logic [1:0] BEEP_LONG  = 2'd2;

	// bit 4 set: position carries no digit
	localparam logic [4:0] NO_DIGIT = 5'h10;
	localparam logic [4:0] POS_DIGIT [16] = '{
		NO_DIGIT, 5'd2, 5'd3, NO_DIGIT,
		5'd4,     5'd5, 5'd6, NO_DIGIT,
		5'd7,     5'd8, 5'd9, NO_DIGIT,
		NO_DIGIT, 5'd0, NO_DIGIT, NO_DIGIT
	};

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	typedef struct packed {
		logic       opcode;
		logic [3:0] key_position;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [1:0]  beep_kind;
		logic        current_mode;
		logic [2:0]  digits_entered;
		logic [15:0] entered_digits;
		logic [5:0]  stored_count;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/keypad_id_enroll_and_check.sv @@
// keypad_id_enroll_and_check: top level, keypad entry, ID table search and enroll.
// Depends on kic_pkg and kic_ram (ID table).
// Digit words (entry not full), cancel and mode words give their result in the cycle after start,
// one per cycle while busy is low. Accept with a full entry walks the table, one read of the
// table RAM per cycle, busy high meanwhile; other accepts and non-digit keys give no result.
// Reset clears mode, entry and enrolled count; the table is not cleared.
`default_nettype none
module keypad_id_enroll_and_check (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire kic_pkg::cmd_t  item,
	output logic                busy,
	output logic                done,
	output kic_pkg::result_t    result
);

	kic_pkg::state_t state_q, state_d;

	logic                       mode_q, mode_d;
	logic [kic_pkg::IdW-1:0]    ent_q, ent_d;
	logic [kic_pkg::EcntW-1:0]  ecnt_q, ecnt_d;
	logic [kic_pkg::CntW-1:0]   cnt_q, cnt_d;
	logic [kic_pkg::CntW-1:0]   idx_q, idx_d;
	logic                       rdv_s1, rdv_d;
	logic                       done_d;
	kic_pkg::result_t           res_d;

	logic                       emit;
	logic [2:0]                 ev;
	logic [1:0]                 beep;
	logic                       we;
	logic                       hit;
	logic [kic_pkg::IdW-1:0]    rdata;
	logic [4:0]                 dig;
	logic [kic_pkg::NibW-1:0]   nib;

	kic_ram #(
		.Width(kic_pkg::IdW),
		.Depth(kic_pkg::MaxEntries)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[kic_pkg::AddrW-1:0]),
		.wdata(ent_q),
		.raddr(idx_q[kic_pkg::AddrW-1:0]),
		.rdata(rdata)
	);

	assign busy = (state_q != kic_pkg::ST_IDLE);
	assign hit  = rdv_s1 && (rdata == ent_q);
	assign dig  = kic_pkg::POS_DIGIT[item.key_position];
	assign nib  = kic_pkg::NibW'(kic_pkg::IdDigits - 1) - kic_pkg::NibW'(ecnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kic_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		ent_d   = ent_q;
		ecnt_d  = ecnt_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		rdv_d   = 1'b0;
		we      = 1'b0;
		emit    = 1'b0;
		ev      = kic_pkg::EV_ECHO;
		beep    = kic_pkg::BEEP_NONE;
		case (state_q)
			kic_pkg::ST_IDLE: begin
				if (start) begin
					if (item.opcode == kic_pkg::OP_MODE) begin
						mode_d = ~mode_q;
						ent_d  = '0;
						ecnt_d = '0;
						emit   = 1'b1;
						ev     = kic_pkg::EV_MODE;
					end else if (item.key_position == kic_pkg::POS_ACCEPT) begin
						if (ecnt_q == kic_pkg::EcntW'(kic_pkg::IdDigits)) begin
							state_d = kic_pkg::ST_SEARCH;
							idx_d   = '0;
						end
					end else if (item.key_position == kic_pkg::POS_CANCEL) begin
						ent_d  = '0;
						ecnt_d = '0;
						emit   = 1'b1;
						ev     = kic_pkg::EV_CANCEL;
					end else if (!dig[4]
						&& ecnt_q < kic_pkg::EcntW'(kic_pkg::IdDigits)) begin
						ent_d  = ent_q | (kic_pkg::IdW'(dig[3:0]) << {nib, 2'b00});
						ecnt_d = ecnt_q + 1'b1;
						emit   = 1'b1;
						ev     = kic_pkg::EV_ECHO;
					end
				end
			end
			kic_pkg::ST_SEARCH: begin
				if (hit || idx_q == cnt_q) begin
					state_d = kic_pkg::ST_IDLE;
					emit    = 1'b1;
					ent_d   = '0;
					ecnt_d  = '0;
					if (!mode_q) begin
						ev   = hit ? kic_pkg::EV_MATCHED : kic_pkg::EV_NOT_ENROLLED;
						beep = hit ? kic_pkg::BEEP_SHORT : kic_pkg::BEEP_LONG;
					end else if (hit) begin
						ev   = kic_pkg::EV_EXISTS;
						beep = kic_pkg::BEEP_LONG;
					end else if (cnt_q < kic_pkg::CntW'(kic_pkg::MaxEntries)) begin
						we    = 1'b1;
						cnt_d = cnt_q + 1'b1;
						ev    = kic_pkg::EV_REGISTERED;
						beep  = kic_pkg::BEEP_SHORT;
					end else begin
						ev   = kic_pkg::EV_FULL;
						beep = kic_pkg::BEEP_LONG;
					end
				end else begin
					rdv_d = 1'b1;
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = kic_pkg::ST_IDLE;
			end
		endcase
		done_d                = emit;
		res_d.event_kind      = ev;
		res_d.beep_kind       = beep;
		res_d.current_mode    = mode_d;
		res_d.digits_entered  = 3'(ecnt_d);
		res_d.entered_digits  = 16'(ent_d);
		res_d.stored_count    = 6'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			ent_q  <= '0;
			ecnt_q <= '0;
			cnt_q  <= '0;
			idx_q  <= '0;
			rdv_s1 <= 1'b0;
			done   <= 1'b0;
		end else begin
			mode_q <= mode_d;
			ent_q  <= ent_d;
			ecnt_q <= ecnt_d;
			cnt_q  <= cnt_d;
			idx_q  <= idx_d;
			rdv_s1 <= rdv_d;
			done   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result <= res_d;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= kic_pkg::CntW'(kic_pkg::MaxEntries))
		else $error("enrolled count beyond table depth");

	a_ecnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ecnt_q <= kic_pkg::EcntW'(kic_pkg::IdDigits))
		else $error("entry count beyond digit count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kic_pkg::ST_SEARCH |-> idx_q <= cnt_q)
		else $error("search index past enrolled count");

	a_write_when: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == kic_pkg::ST_SEARCH && mode_q && !hit
			&& cnt_q < kic_pkg::CntW'(kic_pkg::MaxEntries)))
		else $error("table write outside enroll finish");

	a_search_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == kic_pkg::ST_SEARCH |-> ecnt_q == kic_pkg::EcntW'(kic_pkg::IdDigits))
		else $error("search without full entry");

endmodule
`default_nettype wire

@@ hw/rtl/kic_ram.sv @@
// kic_ram: generic single-clock RAM, one write port, one registered read port.
// No dependencies.
`default_nettype none
module kic_ram #(
	parameter int Width = 16,
	parameter int Depth = 32,
	localparam int AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [Width-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ tb/keypad_id_enroll_and_check_test.sv @@
// Self-checking testbench for keypad_id_enroll_and_check: directed entry, enroll and check
// words, then random ID sequences under three sender idle profiles.
// Depends on kic_pkg and the RTL of keypad_id_enroll_and_check; reads no files.
module keypad_id_enroll_and_check_test;
	timeunit 1ns;
	timeprecision 1ps;

	import kic_pkg::*;

	localparam logic [3:0] POS_KEY_A    = 4'd3;
	localparam logic [3:0] POS_KEY_HASH = 4'd14;
	localparam int         WordsPerPhase = 433;
	localparam int         DrainCycles   = MaxEntries + 10;

	class keypad_scoreboard;
		bit          mode;
		logic [15:0] entry;
		int          n_digits;
		logic [15:0] ids [MaxEntries];
		int          n_ids;
		result_t     pending_events [$];
		int          mismatches;
		int          n_checked;
		int          seen [8];

		function new();
			mode = 1'b0;
			entry = '0;
			n_digits = 0;
			n_ids = 0;
			mismatches = 0;
			n_checked = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function bit digit_of(input logic [3:0] pos, output logic [3:0] d);
			d = 4'd0;
			case (pos)
				4'd1: d = 4'd2;
				4'd2: d = 4'd3;
				4'd4: d = 4'd4;
				4'd5: d = 4'd5;
				4'd6: d = 4'd6;
				4'd8: d = 4'd7;
				4'd9: d = 4'd8;
				4'd10: d = 4'd9;
				4'd13: d = 4'd0;
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// Advance the model by one accepted word; return 1 if it yields an event.
		function bit note_word(input cmd_t w);
			result_t     r;
			bit          hit;
			logic [3:0]  d;
			r = '0;
			if (w.opcode == OP_MODE) begin
				mode = ~mode;
				entry = '0;
				n_digits = 0;
				r.event_kind = EV_MODE;
				r.beep_kind = BEEP_NONE;
			end else if (w.key_position == POS_ACCEPT) begin
				if (n_digits != IdDigits)
					return 1'b0;
				hit = 1'b0;
				for (int i = 0; i < n_ids; i++)
					if (ids[i] == entry)
						hit = 1'b1;
				if (mode == 1'b0) begin
					r.event_kind = hit ? EV_MATCHED : EV_NOT_ENROLLED;
					r.beep_kind = hit ? BEEP_SHORT : BEEP_LONG;
				end else if (hit) begin
					r.event_kind = EV_EXISTS;
					r.beep_kind = BEEP_LONG;
				end else if (n_ids < MaxEntries) begin
					ids[n_ids] = entry;
					n_ids++;
					r.event_kind = EV_REGISTERED;
					r.beep_kind = BEEP_SHORT;
				end else begin
					r.event_kind = EV_FULL;
					r.beep_kind = BEEP_LONG;
				end
				entry = '0;
				n_digits = 0;
			end else if (w.key_position == POS_CANCEL) begin
				entry = '0;
				n_digits = 0;
				r.event_kind = EV_CANCEL;
				r.beep_kind = BEEP_NONE;
			end else begin
				if (!digit_of(w.key_position, d) || n_digits >= IdDigits)
					return 1'b0;
				entry[(IdDigits - 1 - n_digits) * 4 +: 4] = d;
				n_digits++;
				r.event_kind = EV_ECHO;
				r.beep_kind = BEEP_NONE;
			end
			r.current_mode = mode;
			r.digits_entered = 3'(n_digits);
			r.entered_digits = entry;
			r.stored_count = 6'(n_ids);
			pending_events.push_back(r);
			return 1'b1;
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected event kind %0d beep %0d mode %0d n %0d id %h stored %0d",
						$realtime, got.event_kind, got.beep_kind, got.current_mode,
						got.digits_entered, got.entered_digits, got.stored_count);
				return;
			end
			want = pending_events.pop_front();
			n_checked++;
			if (got.event_kind !== want.event_kind || got.beep_kind !== want.beep_kind ||
				got.current_mode !== want.current_mode ||
				got.digits_entered !== want.digits_entered ||
				got.entered_digits !== want.entered_digits ||
				got.stored_count !== want.stored_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"%0t: event %0d expected kind %0d beep %0d mode %0d n %0d id %h ",
						"stored %0d, got kind %0d beep %0d mode %0d n %0d id %h stored %0d"},
						$realtime, n_checked, want.event_kind, want.beep_kind,
						want.current_mode, want.digits_entered, want.entered_digits,
						want.stored_count, got.event_kind, got.beep_kind, got.current_mode,
						got.digits_entered, got.entered_digits, got.stored_count);
			end else begin
				seen[want.event_kind]++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    item = '0;
	logic    busy;
	logic    done;
	result_t result;

	keypad_scoreboard sb;
	int idle_pct;
	int events_expected;
	int words_sent;

	keypad_id_enroll_and_check DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(result);
	end

	function automatic cmd_t key_word(input logic [3:0] pos);
		cmd_t c;
		c.opcode = OP_KEY;
		c.key_position = pos;
		return c;
	endfunction

	function automatic cmd_t digit_word(input logic [3:0] d);
		logic [3:0] pos;
		case (d)
			4'd0: pos = 4'd13;
			4'd2: pos = 4'd1;
			4'd3: pos = 4'd2;
			4'd4: pos = 4'd4;
			4'd5: pos = 4'd5;
			4'd6: pos = 4'd6;
			4'd7: pos = 4'd8;
			4'd8: pos = 4'd9;
			default: pos = 4'd10;
		endcase
		return key_word(pos);
	endfunction

	function automatic cmd_t mode_word();
		cmd_t c;
		c.opcode = OP_MODE;
		c.key_position = 4'($urandom_range(15));
		return c;
	endfunction

	function automatic cmd_t noise_word();
		cmd_t c;
		c.opcode = ($urandom_range(3) == 0) ? OP_MODE : OP_KEY;
		c.key_position = 4'($urandom_range(15));
		return c;
	endfunction

	function automatic logic [3:0] random_digit();
		int d;
		d = $urandom_range(8);
		if (d >= 1)
			d++;
		return 4'(d);
	endfunction

	task automatic send_word(input cmd_t w);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= 5'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy !== 1'b0);
		words_sent++;
		events_expected += sb.note_word(w);
	endtask

	task automatic enter_id(input logic [15:0] id, input bit with_noise);
		for (int k = IdDigits - 1; k >= 0; k--) begin
			if (with_noise && $urandom_range(19) == 0)
				send_word(noise_word());
			send_word(digit_word(id[k * 4 +: 4]));
		end
	endtask

	task automatic random_sequence();
		int          r;
		int          n;
		logic [15:0] id;
		r = $urandom_range(99);
		if (r < 70) begin
			if (sb.n_ids != 0 && $urandom_range(1) == 1)
				id = sb.ids[$urandom_range(sb.n_ids - 1)];
			else
				for (int k = 0; k < IdDigits; k++)
					id[k * 4 +: 4] = random_digit();
			enter_id(id, 1'b1);
			if ($urandom_range(9) == 0)
				send_word(digit_word(random_digit()));
			send_word(key_word(POS_ACCEPT));
		end else if (r < 80) begin
			send_word(mode_word());
		end else if (r < 90) begin
			n = $urandom_range(IdDigits);
			for (int k = 0; k < n; k++)
				send_word(digit_word(random_digit()));
			if ($urandom_range(1) == 1)
				send_word(key_word(POS_CANCEL));
			else
				send_word(mode_word());
		end else begin
			send_word(noise_word());
		end
	endtask

	initial begin
		int pct [3];
		int goal;
		int guard;
		pct = '{11, 69, 0};
		sb = new();
		events_expected = 0;
		words_sent = 0;
		idle_pct = pct[0];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(key_word(POS_ACCEPT));
		send_word(key_word(POS_KEY_A));
		send_word(key_word(POS_KEY_HASH));
		send_word(digit_word(4'd2));
		send_word(key_word(POS_CANCEL));
		enter_id(16'h9870, 1'b0);
		send_word(digit_word(4'd5));
		send_word(key_word(POS_ACCEPT));
		send_word(mode_word());
		enter_id(16'h9870, 1'b0);
		send_word(key_word(POS_ACCEPT));
		enter_id(16'h9870, 1'b0);
		send_word(key_word(POS_ACCEPT));
		send_word(digit_word(4'd4));
		send_word(mode_word());

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = pct[ph];
			goal = words_sent + WordsPerPhase;
			while (words_sent < goal)
				random_sequence();
		end
		start <= 1'b0;

		guard = 0;
		while (sb.pending_events.size() != 0 && guard < 10_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (DrainCycles) @(posedge clk);

		$display("Sent %0d words for %0d expected events, checked %0d; table ended with %0d of %0d IDs.",
			words_sent, events_expected, sb.n_checked, sb.n_ids, MaxEntries);
		$display("Registered %0d, matched %0d, not enrolled %0d, already present %0d, full %0d.",
			sb.seen[EV_REGISTERED], sb.seen[EV_MATCHED], sb.seen[EV_NOT_ENROLLED],
			sb.seen[EV_EXISTS], sb.seen[EV_FULL]);
		if (sb.mismatches == 0 && sb.pending_events.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
